// ----- rtl/tfb_pkg.sv -----
// Shared types and constants for the triple-buffered frame store.
// Holds the func codes, the command word passed from front to back, and queue status.
// No dependencies.
package tfb_pkg;

  localparam int COLOR_W     = 16;
  localparam int COORD_W     = 10;  // covers coordinates 0 to 1023
  localparam int PIX_W       = 20;  // covers a 1024 x 1024 frame
  localparam int OUT_X_W     = 7;
  localparam int OUT_Y_W     = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCOUNT_W    = 3;
  localparam int NUM_STORES  = 3;

  localparam logic [2:0] FUNC_SET_PIXEL = 3'd0;
  localparam logic [2:0] FUNC_FILL      = 3'd1;
  localparam logic [2:0] FUNC_CLEAR     = 3'd2;
  localparam logic [2:0] FUNC_FINISH    = 3'd3;
  localparam logic [2:0] FUNC_RENDER    = 3'd4;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_FILL,
    CMD_COMPARE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [1:0]           store_a;  // target store, or queued store for compare
    logic [1:0]           store_b;  // displayed store for compare
    logic [COLOR_W-1:0]   color;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [PIX_W-1:0]     pix;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic                empty;
    logic [QCOUNT_W-1:0] count;
  } queue_status_t;

  function automatic logic [1:0] next_store(input logic [1:0] s);
    logic [1:0] n;
    n = (s == 2'(NUM_STORES - 1)) ? 2'd0 : s + 2'd1;
    return n;
  endfunction

endpackage

// ----- rtl/tfb_front.sv -----
// Front end: accepts items, tracks buffer roles and scan position, wraps coordinates.
// Emits memory commands to the queue. Depends on tfb_pkg.
module tfb_front import tfb_pkg::*; #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 160
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          func,
  input  logic signed [15:0]  x_coord,
  input  logic signed [15:0]  y_coord,
  input  logic [15:0]         color,
  input  logic                init_busy,
  input  queue_status_t       qstat,
  output logic                busy,
  output logic                push,
  output cmd_t                push_cmd
);

  localparam int FP = WIDTH * HEIGHT;
  localparam int PW = (FP > 1) ? $clog2(FP) : 1;
  localparam int XW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int YW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int RW = 12;
  localparam logic [32:0]   MX     = 33'((64'd1 << 32) / WIDTH);
  localparam logic [32:0]   MY     = 33'((64'd1 << 32) / HEIGHT);
  localparam logic [15:0]   NX16   = 16'(WIDTH);
  localparam logic [15:0]   NY16   = 16'(HEIGHT);
  localparam logic [RW-1:0] NX     = RW'(WIDTH);
  localparam logic [RW-1:0] NY     = RW'(HEIGHT);
  localparam logic [RW-1:0] OFFX   = RW'(32768 % WIDTH);
  localparam logic [RW-1:0] OFFY   = RW'(32768 % HEIGHT);
  localparam logic [PW-1:0] LAST_P = PW'(FP - 1);
  localparam logic [XW-1:0] LAST_X = XW'(WIDTH - 1);

  // r is in [0, 2n); the offset undoes the bias added to make the input unsigned
  function automatic logic [RW-1:0] wrap_fix(input logic [RW-1:0] r, input logic [RW-1:0] n,
                                             input logic [RW-1:0] off);
    logic [RW-1:0] r1;
    logic [RW-1:0] res;
    r1  = (r >= n) ? r - n : r;
    res = (r1 >= off) ? r1 - off : r1 + n - off;
    return res;
  endfunction

  logic [1:0]    draw_idx, draw_idx_next;
  logic [1:0]    shown_idx, shown_idx_next;
  logic [1:0]    queued_idx, queued_idx_next;
  logic          queued_valid, queued_valid_next;
  logic          full, full_next;
  logic [PW-1:0] scan_p, scan_p_next;
  logic [XW-1:0] scan_x, scan_x_next;
  logic [YW-1:0] scan_y, scan_y_next;

  logic          accept;
  logic          cmd_valid;
  cmd_t          cmd_new;
  logic [15:0]   u_x, u_y;
  logic [3:0]    occ;

  logic          s1_valid;
  cmd_t          s1_cmd;
  logic [15:0]   s1_ux, s1_uy;
  logic [48:0]   s1_px, s1_py;
  logic          s2_valid;
  cmd_t          s2_cmd;
  logic [RW-1:0] s2_rx, s2_ry;
  logic [15:0]   qn_x, qn_y;
  logic [15:0]   rem_x, rem_y;

  assign occ    = 4'(qstat.count) + 4'(s1_valid) + 4'(s2_valid);
  assign busy   = init_busy || (occ >= 4'(QUEUE_DEPTH));
  assign accept = start && !busy;

  // bias by half the range so the value is unsigned
  assign u_x = {~x_coord[15], x_coord[14:0]};
  assign u_y = {~y_coord[15], y_coord[14:0]};

  always_comb begin
    draw_idx_next     = draw_idx;
    shown_idx_next    = shown_idx;
    queued_idx_next   = queued_idx;
    queued_valid_next = queued_valid;
    full_next         = full;
    scan_p_next       = scan_p;
    scan_x_next       = scan_x;
    scan_y_next       = scan_y;
    cmd_valid         = 1'b0;
    cmd_new           = '0;
    if (accept) begin
      unique case (func)
        FUNC_SET_PIXEL: begin
          cmd_valid       = !full;
          cmd_new.kind    = CMD_WRITE;
          cmd_new.store_a = draw_idx;
          cmd_new.color   = color;
        end
        FUNC_FILL: begin
          cmd_valid       = !full;
          cmd_new.kind    = CMD_FILL;
          cmd_new.store_a = draw_idx;
          cmd_new.color   = color;
        end
        FUNC_CLEAR: begin
          cmd_valid       = !full;
          cmd_new.kind    = CMD_FILL;
          cmd_new.store_a = draw_idx;
        end
        FUNC_FINISH: begin
          if (!queued_valid) begin
            queued_idx_next   = draw_idx;
            queued_valid_next = 1'b1;
            draw_idx_next     = next_store(draw_idx);
            cmd_valid         = 1'b1;
            cmd_new.kind      = CMD_FILL;
            cmd_new.store_a   = next_store(draw_idx);
          end else begin
            full_next = 1'b1;
          end
        end
        FUNC_RENDER: begin
          if (queued_valid) begin
            cmd_valid       = 1'b1;
            cmd_new.kind    = CMD_COMPARE;
            cmd_new.store_a = queued_idx;
            cmd_new.store_b = shown_idx;
            cmd_new.x       = COORD_W'(scan_x);
            cmd_new.y       = COORD_W'(scan_y);
            cmd_new.pix     = PIX_W'(scan_p);
            cmd_new.last    = (scan_p == LAST_P);
            if (scan_p == LAST_P) begin
              shown_idx_next    = queued_idx;
              queued_valid_next = 1'b0;
              full_next         = 1'b0;
              scan_p_next       = '0;
              scan_x_next       = '0;
              scan_y_next       = '0;
            end else begin
              scan_p_next = scan_p + 1'b1;
              if (scan_x == LAST_X) begin
                scan_x_next = '0;
                scan_y_next = scan_y + 1'b1;
              end else begin
                scan_x_next = scan_x + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_idx     <= 2'd0;
      shown_idx    <= 2'd2;
      queued_idx   <= 2'd0;
      queued_valid <= 1'b0;
      full         <= 1'b0;
      scan_p       <= '0;
      scan_x       <= '0;
      scan_y       <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      draw_idx     <= draw_idx_next;
      shown_idx    <= shown_idx_next;
      queued_idx   <= queued_idx_next;
      queued_valid <= queued_valid_next;
      full         <= full_next;
      scan_p       <= scan_p_next;
      scan_x       <= scan_x_next;
      scan_y       <= scan_y_next;
      s1_valid     <= cmd_valid;
      s2_valid     <= s1_valid;
    end
  end

  // coordinate wrap: reciprocal multiply, then remainder, then one correction
  assign qn_x  = s1_px[47:32] * NX16;
  assign qn_y  = s1_py[47:32] * NY16;
  assign rem_x = s1_ux - qn_x;
  assign rem_y = s1_uy - qn_y;

  always_ff @(posedge clk) begin
    s1_cmd <= cmd_new;
    s1_ux  <= u_x;
    s1_uy  <= u_y;
    s1_px  <= u_x * MX;
    s1_py  <= u_y * MY;
    s2_cmd <= s1_cmd;
    s2_rx  <= RW'(rem_x);
    s2_ry  <= RW'(rem_y);
  end

  always_comb begin
    push     = s2_valid;
    push_cmd = s2_cmd;
    if (s2_cmd.kind == CMD_WRITE) begin
      push_cmd.x = COORD_W'(wrap_fix(s2_rx, NX, OFFX));
      push_cmd.y = COORD_W'(wrap_fix(s2_ry, NY, OFFY));
    end
  end

endmodule

// ----- rtl/tfb_queue.sv -----
// Command queue between front and back ends.
// Small register FIFO of cmd_t entries. Depends on tfb_pkg.
module tfb_queue import tfb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t qstat
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ----- rtl/tfb_back.sv -----
// Back end: owns the three frame stores and carries out write, fill and compare commands.
// Runs the post-reset clearing sweep. Depends on tfb_pkg.
module tfb_back import tfb_pkg::*; #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 160
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                head,
  input  queue_status_t       qstat,
  output logic                pop,
  output logic                init_busy,
  output logic                strobe,
  output logic [OUT_X_W-1:0]  out_x,
  output logic [OUT_Y_W-1:0]  out_y,
  output logic [COLOR_W-1:0]  out_color,
  output logic                is_write,
  output logic                frame_done
);

  localparam int FP    = WIDTH * HEIGHT;
  localparam int TOTAL = NUM_STORES * FP;
  localparam int AW    = $clog2(TOTAL);
  localparam logic [AW-1:0] WIDTH_C = AW'(WIDTH);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  function automatic logic [AW-1:0] store_base(input logic [1:0] s);
    logic [AW-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = AW'(FP);
      default: b = AW'(2 * FP);
    endcase
    return b;
  endfunction

  logic [COLOR_W-1:0] mem [TOTAL];

  state_t             state;
  logic [AW-1:0]      sweep_addr;
  logic [AW-1:0]      sweep_last;
  logic [COLOR_W-1:0] sweep_color;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [COLOR_W-1:0] wdata;
  logic               rd_en;
  logic [AW-1:0]      ra, rb;

  logic               rd_valid;
  logic [COLOR_W-1:0] rd_a, rd_b;
  logic [COORD_W-1:0] rd_x, rd_y;
  logic               rd_last;
  logic               differ;

  assign pop    = (state == ST_RUN) && !qstat.empty;
  assign differ = (rd_a != rd_b);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = head.color;
    rd_en = 1'b0;
    ra    = '0;
    rb    = '0;
    unique case (state)
      ST_RUN: begin
        if (pop) begin
          case (head.kind)
            CMD_WRITE: begin
              we    = 1'b1;
              waddr = store_base(head.store_a) + AW'(head.y) * WIDTH_C + AW'(head.x);
            end
            CMD_COMPARE: begin
              rd_en = 1'b1;
              ra    = store_base(head.store_a) + AW'(head.pix);
              rb    = store_base(head.store_b) + AW'(head.pix);
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_addr;
        wdata = sweep_color;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_last  <= AW'(TOTAL - 1);
      sweep_color <= '0;
      init_busy   <= 1'b1;
      rd_valid    <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      strobe   <= rd_valid && (differ || rd_last);
      unique case (state)
        ST_RUN: begin
          if (pop && head.kind == CMD_FILL) begin
            state       <= ST_SWEEP;
            sweep_addr  <= store_base(head.store_a);
            sweep_last  <= store_base(head.store_a) + AW'(FP - 1);
            sweep_color <= head.color;
          end
        end
        ST_SWEEP: begin
          if (sweep_addr == sweep_last) begin
            state     <= ST_RUN;
            init_busy <= 1'b0;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) begin
      rd_a    <= mem[ra];
      rd_b    <= mem[rb];
      rd_x    <= head.x;
      rd_y    <= head.y;
      rd_last <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    out_x      <= differ ? OUT_X_W'(rd_x) : '0;
    out_y      <= differ ? OUT_Y_W'(rd_y) : '0;
    out_color  <= differ ? rd_a : '0;
    is_write   <= differ;
    frame_done <= rd_last;
  end

endmodule

// ----- rtl/triple_frame_buffer_diff_update.sv -----
// Triple-buffered RGB565 frame store with differential panel update.
// Items are taken one per cycle while the 4-entry command queue has room; a set pixel or
// render step costs one frame-store access, fill/clear/finish sweep WIDTH*HEIGHT words.
// A render result passes the front pipeline, queue, store read and an output register;
// results cannot be stalled. After reset busy stays high while all stores are cleared.
module triple_frame_buffer_diff_update import tfb_pkg::*; #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 160
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          func,
  input  logic signed [15:0]  x_coord,
  input  logic signed [15:0]  y_coord,
  input  logic [15:0]         color,
  output logic                busy,
  output logic                strobe,
  output logic [OUT_X_W-1:0]  out_x,
  output logic [OUT_Y_W-1:0]  out_y,
  output logic [COLOR_W-1:0]  out_color,
  output logic                is_write,
  output logic                frame_done
);

  logic          init_busy;
  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;
  queue_status_t qstat;

  tfb_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .color     (color),
    .init_busy (init_busy),
    .qstat     (qstat),
    .busy      (busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  tfb_back #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .init_busy  (init_busy),
    .strobe     (strobe),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_color  (out_color),
    .is_write   (is_write),
    .frame_done (frame_done)
  );

endmodule
